// ----- design/run_length_bwt_backward_step_defines.svh -----
// Assertion macros used by the backward-step sequencer (rlbs_ctrl).
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef RUN_LENGTH_BWT_BACKWARD_STEP_DEFINES_SVH
`define RUN_LENGTH_BWT_BACKWARD_STEP_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define RLBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rlbs assertion failed");

// The antecedent implies the consequent in the next cycle.
`define RLBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rlbs assertion failed");

`endif

// ----- design/rlbs_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the
// run-length BWT backward step. No dependencies.
`default_nettype none

package rlbs_pkg;

  localparam int NUM_CONTEXTS = 256;
  localparam int MAX_PREDS    = 16;
  localparam int MAX_RUNS     = 256;
  localparam int POS_WIDTH    = 24;

  localparam int CW   = $clog2(NUM_CONTEXTS);
  localparam int PW   = $clog2(MAX_PREDS);
  localparam int RW   = $clog2(MAX_RUNS);
  localparam int KW   = $clog2(MAX_PREDS + 1);
  localparam int JW   = $clog2(MAX_RUNS + 1);
  localparam int TOTW = RW + 8;
  localparam int AW   = ((POS_WIDTH > TOTW) ? POS_WIDTH : TOTW) + 2;

  localparam int PRED_DW = 8 + POS_WIDTH;
  localparam int RUN_DW  = 8 + 4;
  localparam int CNT_DW  = KW + JW;

  localparam logic [AW-1:0] POS_MASK = AW'((64'd1 << POS_WIDTH) - 64'd1);

  typedef enum logic [2:0] {
    CMD_WR_PRED  = 3'd0,
    CMD_WR_RUN   = 3'd1,
    CMD_SET_LEN  = 3'd2,
    CMD_INTERVAL = 3'd3,
    CMD_POSITION = 3'd4,
    CMD_SIZE     = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_PAST_END  = 3'd2,
    ST_REVERSED  = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    RES_NF   = 3'd0,
    RES_PAST = 3'd1,
    RES_REV  = 3'd2,
    RES_SIZE = 3'd3,
    RES_INT  = 3'd4,
    RES_POS  = 3'd5
  } res_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic cnt_load;
    logic walk_reset;
    logic tot_add;
    logic k_clr;
    logic k_inc;
    logic k_from_idx;
    logic found;
    logic pbase;
    logic pos_adv;
    logic walk_adv;
    logic phase_a;
    logic fin;
    res_e res_sel;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_size;
    logic is_int;
    logic j_lt_rc;
    logic k_lt_pc;
    logic sym_hit;
    logic lo_gt_tot;
    logic hi_lt_lo;
    logic hi_gt_tot;
    logic rc_zero;
    logic pos_adv;
    logic walk_adv;
    logic idx_ge_pc;
    logic tgt_hi;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/rlbs_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module rlbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read of the addressed entry.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ----- design/rlbs_ctrl.sv -----
// Sequencing state machine of the backward step.
// Depends on rlbs_pkg and the shared assertion macros.
`default_nettype none
`include "run_length_bwt_backward_step_defines.svh"

module rlbs_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic [2:0]           command_i,
  input  wire rlbs_pkg::dp_status_t st_i,
  output logic                      in_ready_o,
  output rlbs_pkg::ctrl_cmd_t       cmd_o
);
  import rlbs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CNT   = 7'b0000010,
    S_TOT   = 7'b0000100,
    S_SRCH  = 7'b0001000,
    S_PSCN  = 7'b0010000,
    S_PBASE = 7'b0100000,
    S_WALK  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   is_query;

  assign in_ready_o = (state_q == S_IDLE);
  assign is_query   = (command_i == CMD_INTERVAL) || (command_i == CMD_POSITION) ||
                      (command_i == CMD_SIZE);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (is_query) state_d = S_CNT;
        end
      end
      S_CNT: begin
        cmd_o.cnt_load = 1'b1;
        state_d        = S_TOT;
      end
      S_TOT: begin
        if (st_i.j_lt_rc) begin
          cmd_o.tot_add = 1'b1;
        end else if (st_i.is_size) begin
          if (st_i.out_free) begin
            cmd_o.fin     = 1'b1;
            cmd_o.res_sel = RES_SIZE;
            state_d       = S_IDLE;
          end
        end else if (st_i.is_int) begin
          cmd_o.walk_reset = 1'b1;
          cmd_o.k_clr      = 1'b1;
          state_d          = S_SRCH;
        end else begin
          cmd_o.walk_reset = 1'b1;
          state_d          = S_PSCN;
        end
      end
      S_SRCH: begin
        if (!st_i.k_lt_pc || (st_i.sym_hit &&
            (st_i.lo_gt_tot || st_i.hi_lt_lo || st_i.hi_gt_tot))) begin
          // Error outcomes, checked in the order the interface defines.
          if (st_i.out_free) begin
            cmd_o.fin = 1'b1;
            priority if (!st_i.k_lt_pc) cmd_o.res_sel = RES_NF;
            else if (st_i.lo_gt_tot)    cmd_o.res_sel = RES_PAST;
            else if (st_i.hi_lt_lo)     cmd_o.res_sel = RES_REV;
            else                        cmd_o.res_sel = RES_PAST;
            state_d = S_IDLE;
          end
        end else if (st_i.sym_hit) begin
          cmd_o.found = 1'b1;
          state_d     = S_WALK;
        end else begin
          cmd_o.k_inc = 1'b1;
        end
      end
      S_PSCN: begin
        if (st_i.rc_zero || st_i.lo_gt_tot) begin
          if (st_i.out_free) begin
            cmd_o.fin     = 1'b1;
            cmd_o.res_sel = RES_PAST;
            state_d       = S_IDLE;
          end
        end else if (st_i.pos_adv) begin
          cmd_o.pos_adv = 1'b1;
        end else if (st_i.idx_ge_pc) begin
          if (st_i.out_free) begin
            cmd_o.fin     = 1'b1;
            cmd_o.res_sel = RES_NF;
            state_d       = S_IDLE;
          end
        end else begin
          cmd_o.k_from_idx = 1'b1;
          cmd_o.walk_reset = 1'b1;
          state_d          = S_PBASE;
        end
      end
      S_PBASE: begin
        cmd_o.pbase = 1'b1;
        state_d     = S_WALK;
      end
      S_WALK: begin
        if (st_i.walk_adv) begin
          cmd_o.walk_adv = 1'b1;
        end else if (st_i.is_int && !st_i.tgt_hi) begin
          cmd_o.phase_a = 1'b1;
        end else if (st_i.out_free) begin
          cmd_o.fin     = 1'b1;
          cmd_o.res_sel = st_i.is_int ? RES_INT : RES_POS;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A result is only produced when the output register can take it.
  `RLBS_ASSERT_IMP(a_fin_free, cmd_o.fin, st_i.out_free)
  // Finishing an item always returns the sequencer to idle.
  `RLBS_ASSERT_NXT(a_fin_idle, cmd_o.fin, state_q == S_IDLE)
  // An accepted query starts by reading the list lengths.
  `RLBS_ASSERT_NXT(a_query_cnt, in_valid_i && in_ready_o && is_query, state_q == S_CNT)

endmodule

`default_nettype wire

// ----- design/rlbs_dpath.sv -----
// Datapath of the backward step: table memories, run walker and result register.
// Depends on rlbs_pkg and rlbs_ram.
`default_nettype none

module rlbs_dpath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rlbs_pkg::ctrl_cmd_t cmd_i,
  input  wire logic [2:0]          command_i,
  input  wire logic [7:0]          context_req_i,
  input  wire logic [7:0]          slot_i,
  input  wire logic [7:0]          sync_value_i,
  input  wire logic [23:0]         base_count_i,
  input  wire logic [7:0]          run_length_i,
  input  wire logic [3:0]          run_symbol_index_i,
  input  wire logic [4:0]          pred_count_i,
  input  wire logic [8:0]          run_count_i,
  input  wire logic [23:0]         low_pos_i,
  input  wire logic [23:0]         high_pos_i,
  input  wire logic                out_ready_i,
  output rlbs_pkg::dp_status_t     st_o,
  output logic                     out_valid_o,
  output logic [2:0]               status_o,
  output logic [23:0]              new_low_o,
  output logic [23:0]              new_high_o,
  output logic [23:0]              match_count_o,
  output logic [7:0]               prev_sync_o
);
  import rlbs_pkg::*;

  // Captured item and per-query state.
  logic [2:0]    cmd_q;
  logic [CW-1:0] ctx_q;
  logic [7:0]    sx_q;
  logic [23:0]   lo_q, hi_q;
  logic [KW-1:0] pc_q, k_q, k_d;
  logic [JW-1:0] rc_q, j_q, j_d;
  logic [AW-1:0] tot_q, n_q, r_q, a_q;
  logic [PW-1:0] kx_q;
  logic          tgt_hi_q;
  logic [7:0]    ps_q;
  logic [NUM_CONTEXTS-1:0] cnt_vld_q;

  logic          acc;
  logic          we_pred, we_run, we_cnt;
  logic [PRED_DW-1:0] pred_rd;
  logic [RUN_DW-1:0]  run_rd;
  logic [CNT_DW-1:0]  cnt_rd, cnt_wd;
  logic [CW+PW-1:0]   pred_addr;
  logic [CW+RW-1:0]   run_addr;
  logic [KW-1:0] pc_sat;
  logic [JW-1:0] rc_sat;

  logic [7:0]    run_len;
  logic [3:0]    run_idx;
  logic [7:0]    pred_sym;
  logic [POS_WIDTH-1:0] pred_base;
  logic [AW-1:0] tgt, lo_w, hi_w, n_len, val;
  logic          j_lt_rc, hit;

  assign acc = cmd_i.capture;

  // Table writes happen in the cycle the load item is accepted.
  assign we_pred = acc && (command_i == CMD_WR_PRED) && (32'(slot_i) < MAX_PREDS);
  assign we_run  = acc && (command_i == CMD_WR_RUN) && (32'(slot_i) < MAX_RUNS);
  assign we_cnt  = acc && (command_i == CMD_SET_LEN);

  assign pc_sat = (32'(pred_count_i) > MAX_PREDS) ? KW'(MAX_PREDS) : KW'(pred_count_i);
  assign rc_sat = (32'(run_count_i) > MAX_RUNS) ? JW'(MAX_RUNS) : JW'(run_count_i);
  assign cnt_wd = {pc_sat, rc_sat};

  // Read addresses follow the next walk indices so data matches j_q and k_q.
  assign pred_addr = we_pred ? {context_req_i[CW-1:0], slot_i[PW-1:0]}
                             : {ctx_q, k_d[PW-1:0]};
  assign run_addr  = we_run ? {context_req_i[CW-1:0], slot_i[RW-1:0]}
                            : {ctx_q, j_d[RW-1:0]};

  rlbs_ram #(.WIDTH(PRED_DW), .DEPTH(NUM_CONTEXTS * MAX_PREDS)) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (we_pred),
    .addr_i  (pred_addr),
    .wdata_i ({sync_value_i, base_count_i}),
    .rdata_o (pred_rd)
  );

  rlbs_ram #(.WIDTH(RUN_DW), .DEPTH(NUM_CONTEXTS * MAX_RUNS)) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (we_run),
    .addr_i  (run_addr),
    .wdata_i ({run_length_i, run_symbol_index_i}),
    .rdata_o (run_rd)
  );

  rlbs_ram #(.WIDTH(CNT_DW), .DEPTH(NUM_CONTEXTS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (we_cnt),
    .addr_i  (context_req_i[CW-1:0]),
    .wdata_i (cnt_wd),
    .rdata_o (cnt_rd)
  );

  // Valid bits stand in for the all-zero reset of the length table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (we_cnt) begin
      cnt_vld_q[context_req_i[CW-1:0]] <= 1'b1;
    end
  end

  assign run_len   = run_rd[11:4];
  assign run_idx   = run_rd[3:0];
  assign pred_sym  = pred_rd[PRED_DW-1 -: 8];
  assign pred_base = pred_rd[POS_WIDTH-1:0];

  // Walk arithmetic.
  assign lo_w    = AW'(lo_q);
  assign hi_w    = AW'(hi_q);
  assign tgt     = tgt_hi_q ? hi_w : lo_w;
  assign n_len   = n_q + AW'(run_len);
  assign j_lt_rc = (j_q < rc_q);
  assign hit     = j_lt_rc && (run_idx == kx_q);
  assign val     = hit ? (r_q + (tgt - n_q)) : r_q;

  // Next walk indices.
  always_comb begin
    j_d = j_q;
    if (cmd_i.cnt_load || cmd_i.walk_reset) begin
      j_d = '0;
    end else if (cmd_i.tot_add || cmd_i.pos_adv || cmd_i.walk_adv) begin
      j_d = j_q + JW'(1);
    end
    k_d = k_q;
    priority if (cmd_i.k_clr) k_d = '0;
    else if (cmd_i.k_inc)     k_d = k_q + KW'(1);
    else if (cmd_i.k_from_idx) k_d = KW'(run_idx);
  end

  // Query registers.
  always_ff @(posedge clk_i) begin
    j_q <= j_d;
    k_q <= k_d;
    if (acc) begin
      cmd_q <= command_i;
      ctx_q <= context_req_i[CW-1:0];
      sx_q  <= sync_value_i;
      lo_q  <= low_pos_i;
      hi_q  <= high_pos_i;
    end
    if (cmd_i.cnt_load) begin
      pc_q  <= cnt_vld_q[ctx_q] ? cnt_rd[CNT_DW-1 -: KW] : '0;
      rc_q  <= cnt_vld_q[ctx_q] ? cnt_rd[JW-1:0] : '0;
      tot_q <= '0;
    end else if (cmd_i.tot_add) begin
      tot_q <= tot_q + AW'(run_len);
    end
    if (cmd_i.walk_reset) begin
      n_q <= '0;
    end else if (cmd_i.pos_adv || cmd_i.walk_adv) begin
      n_q <= n_len;
    end
    if (cmd_i.found || cmd_i.pbase) begin
      r_q <= AW'(pred_base);
    end else if (cmd_i.walk_adv && (run_idx == kx_q)) begin
      r_q <= r_q + AW'(run_len);
    end
    if (cmd_i.found) begin
      kx_q     <= k_q[PW-1:0];
      tgt_hi_q <= 1'b0;
    end else if (cmd_i.k_from_idx) begin
      kx_q     <= PW'(run_idx);
      tgt_hi_q <= 1'b0;
    end else if (cmd_i.phase_a) begin
      tgt_hi_q <= 1'b1;
    end
    if (cmd_i.phase_a) a_q  <= val;
    if (cmd_i.pbase)   ps_q <= pred_sym;
  end

  // Status toward the controller.
  always_comb begin
    st_o.is_size   = (cmd_q == CMD_SIZE);
    st_o.is_int    = (cmd_q == CMD_INTERVAL);
    st_o.j_lt_rc   = j_lt_rc;
    st_o.k_lt_pc   = (k_q < pc_q);
    st_o.sym_hit   = (pred_sym == sx_q);
    st_o.lo_gt_tot = (lo_w > tot_q);
    st_o.hi_lt_lo  = (hi_q < lo_q);
    st_o.hi_gt_tot = (hi_w > tot_q);
    st_o.rc_zero   = (rc_q == '0);
    st_o.pos_adv   = ((JW+1)'(j_q) + (JW+1)'(1) < (JW+1)'(rc_q)) && (n_len < lo_w);
    st_o.walk_adv  = j_lt_rc && (n_len < tgt);
    st_o.idx_ge_pc = (KW'(run_idx) >= pc_q);
    st_o.tgt_hi    = tgt_hi_q;
    st_o.out_free  = !out_valid_o || out_ready_i;
  end

  // Result register, loaded when the controller finishes an item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      status_o      <= ST_OK;
      new_low_o     <= '0;
      new_high_o    <= '0;
      match_count_o <= '0;
      prev_sync_o   <= '0;
      unique case (cmd_i.res_sel)
        RES_NF:   status_o <= ST_NOT_FOUND;
        RES_PAST: status_o <= ST_PAST_END;
        RES_REV:  status_o <= ST_REVERSED;
        RES_SIZE: begin
          if (tot_q > POS_MASK) status_o <= ST_OVERFLOW;
          else new_high_o <= tot_q[23:0];
        end
        RES_INT: begin
          if ((a_q > POS_MASK) || (val > POS_MASK)) begin
            status_o <= ST_OVERFLOW;
          end else begin
            new_low_o     <= a_q[23:0];
            new_high_o    <= val[23:0];
            match_count_o <= val[23:0] - a_q[23:0];
          end
        end
        RES_POS: begin
          if (val > POS_MASK) begin
            status_o <= ST_OVERFLOW;
          end else begin
            new_low_o   <= val[23:0];
            prev_sync_o <= ps_q;
          end
        end
        default: status_o <= ST_OK;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/run_length_bwt_backward_step.sv -----
// Top level of the run-length BWT backward step.
// Depends on rlbs_pkg, rlbs_ctrl and rlbs_dpath.
`default_nettype none

// Load items (write predecessor, write run, set list lengths) are absorbed
// in the cycle they are accepted and give no result. A query first reads the
// context's list lengths, then sums the run lengths, one run per cycle. A
// size query finishes there. An interval step then scans the predecessor
// list, one entry per cycle, and walks the run list once, one run per cycle,
// pausing once as it turns from the low to the high bound. A position step
// scans runs to find the landing run, reads its predecessor entry and walks
// again. The run memory is single-port and read once per cycle. A result
// waits in an output register while the next item is accepted.
module run_length_bwt_backward_step (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [7:0]  context_req_i,
  input  wire logic [7:0]  slot_i,
  input  wire logic [7:0]  sync_value_i,
  input  wire logic [23:0] base_count_i,
  input  wire logic [7:0]  run_length_i,
  input  wire logic [3:0]  run_symbol_index_i,
  input  wire logic [4:0]  pred_count_i,
  input  wire logic [8:0]  run_count_i,
  input  wire logic [23:0] low_pos_i,
  input  wire logic [23:0] high_pos_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [23:0]      new_low_o,
  output logic [23:0]      new_high_o,
  output logic [23:0]      match_count_o,
  output logic [7:0]       prev_sync_o
);
  import rlbs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // Sequencer.
  rlbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .st_i       (st),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // Tables, walker and result register.
  rlbs_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .command_i          (command_i),
    .context_req_i      (context_req_i),
    .slot_i             (slot_i),
    .sync_value_i       (sync_value_i),
    .base_count_i       (base_count_i),
    .run_length_i       (run_length_i),
    .run_symbol_index_i (run_symbol_index_i),
    .pred_count_i       (pred_count_i),
    .run_count_i        (run_count_i),
    .low_pos_i          (low_pos_i),
    .high_pos_i         (high_pos_i),
    .out_ready_i        (out_ready_i),
    .st_o               (st),
    .out_valid_o        (out_valid_o),
    .status_o           (status_o),
    .new_low_o          (new_low_o),
    .new_high_o         (new_high_o),
    .match_count_o      (match_count_o),
    .prev_sync_o        (prev_sync_o)
  );

endmodule

`default_nettype wire
